// ===== hw/rtl/lsbs_pkg.sv =====
// Shared types and constants for the LSB steganography embed/extract unit.
// No dependencies; every other file imports this package.
`default_nettype none

package lsbs_pkg;

    localparam int SIG_LEN_DEF  = 3;
    localparam int NUM_LANES    = 8;
    localparam int BYTE_W       = 8;
    localparam int HDR_POS_W    = 4;
    localparam int LEN_W        = 32;
    localparam int SIG_W        = 24;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE    = 2'd0,
        CFG_SIG     = 2'd1,
        CFG_MSG_LEN = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_SIG  = 2'd0,
        PH_LEN  = 2'd1,
        PH_MSG  = 2'd2,
        PH_PAST = 2'd3
    } phase_t;

    // Per-item control result handed from the header/counter logic to the lanes.
    typedef struct packed {
        logic [BYTE_W-1:0] payload;
        phase_t            phase;
        logic              sig_ok;
        logic              last;
        logic              embed_en;
    } ctrl_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lsb_stego_embed_extract_unit.sv =====
// LSB steganography embed/extract unit: one group of eight carrier bytes per item.
// The result of an accepted item is registered in the output register in the cycle after it is accepted.
// Throughput: one item per cycle unless a full output register is stalled; the only storage
// between input and output is the output register, which refills in the cycle it is taken.
// Reset clears configuration, header position, counters and the output valid flag.
// Depends on lsbs_pkg, lsbs_ctrl and lsbs_lane.
`default_nettype none

module lsb_stego_embed_extract_unit
    import lsbs_pkg::*;
#(
    parameter int SIG_LEN = SIG_LEN_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [BYTE_W-1:0]      carrier_0,
    input  wire logic [BYTE_W-1:0]      carrier_1,
    input  wire logic [BYTE_W-1:0]      carrier_2,
    input  wire logic [BYTE_W-1:0]      carrier_3,
    input  wire logic [BYTE_W-1:0]      carrier_4,
    input  wire logic [BYTE_W-1:0]      carrier_5,
    input  wire logic [BYTE_W-1:0]      carrier_6,
    input  wire logic [BYTE_W-1:0]      carrier_7,
    input  wire logic [BYTE_W-1:0]      msg_byte,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [BYTE_W-1:0]           out_0,
    output logic [BYTE_W-1:0]           out_1,
    output logic [BYTE_W-1:0]           out_2,
    output logic [BYTE_W-1:0]           out_3,
    output logic [BYTE_W-1:0]           out_4,
    output logic [BYTE_W-1:0]           out_5,
    output logic [BYTE_W-1:0]           out_6,
    output logic [BYTE_W-1:0]           out_7,
    output logic [BYTE_W-1:0]           data_byte,
    output logic [1:0]                  phase,
    output logic                        sig_ok,
    output logic                        last
);

    logic                    accept;
    logic [BYTE_W-1:0]       carrier   [NUM_LANES];
    logic [BYTE_W-1:0]       lane_out  [NUM_LANES];
    logic [NUM_LANES-1:0]    lane_lsb;
    logic [BYTE_W-1:0]       extracted;
    ctrl_res_t               res;

    logic                    out_valid_reg;
    logic [BYTE_W-1:0]       out_byte_reg [NUM_LANES];
    ctrl_res_t               res_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign carrier[0] = carrier_0;
    assign carrier[1] = carrier_1;
    assign carrier[2] = carrier_2;
    assign carrier[3] = carrier_3;
    assign carrier[4] = carrier_4;
    assign carrier[5] = carrier_5;
    assign carrier[6] = carrier_6;
    assign carrier[7] = carrier_7;

    // Lane 0 carries the most significant payload bit.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
            extracted[NUM_LANES-1-i] = lane_lsb[i];
    end

    lsbs_ctrl #(
        .SIG_LEN (SIG_LEN)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .extracted (extracted),
        .msg_byte  (msg_byte),
        .res       (res)
    );

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        lsbs_lane u_lane (
            .carrier     (carrier[g]),
            .bit_in      (res.payload[NUM_LANES-1-g]),
            .embed_en    (res.embed_en),
            .lsb         (lane_lsb[g]),
            .carrier_out (lane_out[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!in_stall)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < NUM_LANES; i++)
                out_byte_reg[i] <= lane_out[i];
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_0     = out_byte_reg[0];
    assign out_1     = out_byte_reg[1];
    assign out_2     = out_byte_reg[2];
    assign out_3     = out_byte_reg[3];
    assign out_4     = out_byte_reg[4];
    assign out_5     = out_byte_reg[5];
    assign out_6     = out_byte_reg[6];
    assign out_7     = out_byte_reg[7];
    assign data_byte = res_reg.payload;
    assign phase     = res_reg.phase;
    assign sig_ok    = res_reg.sig_ok;
    assign last      = res_reg.last;

    a_last_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (phase == PH_MSG))
        else $error("last flag outside the message phase");

    a_past_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (phase == PH_PAST)) |-> ((data_byte == '0) && !last))
        else $error("result past the payload carries data");

    a_past_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !res.embed_en) |=> ((out_0 == $past(carrier_0))
                                       && (out_7 == $past(carrier_7))))
        else $error("carrier altered while embedding is off");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with an empty output register");

endmodule

`default_nettype wire

// ===== hw/rtl/lsbs_lane.sv =====
// One carrier-byte lane: picks off the LSB and optionally replaces it.
// Depends on lsbs_pkg.
`default_nettype none

module lsbs_lane
    import lsbs_pkg::*;
(
    input  wire logic [BYTE_W-1:0] carrier,
    input  wire logic              bit_in,
    input  wire logic              embed_en,
    output logic                   lsb,
    output logic [BYTE_W-1:0]      carrier_out
);

    assign lsb         = carrier[0];
    assign carrier_out = embed_en ? {carrier[BYTE_W-1:1], bit_in} : carrier;

endmodule

`default_nettype wire

// ===== hw/rtl/lsbs_ctrl.sv =====
// Configuration registers, header position, message counters and signature check.
// Depends on lsbs_pkg.
`default_nettype none

module lsbs_ctrl
    import lsbs_pkg::*;
#(
    parameter int SIG_LEN = SIG_LEN_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   accept,
    input  wire logic [BYTE_W-1:0]      extracted,
    input  wire logic [BYTE_W-1:0]      msg_byte,
    output ctrl_res_t                   res
);

    localparam logic [HDR_POS_W-1:0] SIG_END = HDR_POS_W'(SIG_LEN);
    localparam logic [HDR_POS_W-1:0] HDR_END = HDR_POS_W'(SIG_LEN + 4);

    logic                   mode_reg;
    logic [SIG_W-1:0]       signature_reg;
    logic [LEN_W-1:0]       message_length_reg;
    logic [HDR_POS_W-1:0]   header_pos_reg, header_pos_next;
    logic [LEN_W-1:0]       bytes_done_reg, bytes_done_next;
    logic [LEN_W-1:0]       length_seen_reg, length_seen_next;
    logic                   mismatch_seen_reg, mismatch_seen_next;

    logic [LEN_W-1:0]       total;
    logic [LEN_W-1:0]       bytes_done_inc;
    logic [HDR_POS_W-1:0]   sig_dist;
    logic [HDR_POS_W-1:0]   len_pos;
    logic [BYTE_W-1:0]      sig_expect;
    logic [BYTE_W-1:0]      len_byte;
    phase_t                 phase;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= 1'b0;
            signature_reg      <= '0;
            message_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MODE:    mode_reg           <= cfg_data[0];
                CFG_SIG:     signature_reg      <= cfg_data[SIG_W-1:0];
                CFG_MSG_LEN: message_length_reg <= cfg_data[LEN_W-1:0];
                default:     ;
            endcase
        end
    end

    assign total          = mode_reg ? length_seen_reg : message_length_reg;
    assign bytes_done_inc = bytes_done_reg + LEN_W'(1);
    assign sig_dist       = SIG_END - HDR_POS_W'(1) - header_pos_reg;
    assign len_pos        = header_pos_reg - SIG_END;

    always_comb
    begin
        if (header_pos_reg < SIG_END)
            phase = PH_SIG;
        else if (header_pos_reg < HDR_END)
            phase = PH_LEN;
        else if (bytes_done_reg < total)
            phase = PH_MSG;
        else
            phase = PH_PAST;
    end

    // Signature bytes beyond the register width read as zero.
    always_comb
    begin
        case (sig_dist)
            4'd0:    sig_expect = signature_reg[7:0];
            4'd1:    sig_expect = signature_reg[15:8];
            4'd2:    sig_expect = signature_reg[23:16];
            default: sig_expect = '0;
        endcase
    end

    always_comb
    begin
        case (len_pos[1:0])
            2'd0:    len_byte = message_length_reg[31:24];
            2'd1:    len_byte = message_length_reg[23:16];
            2'd2:    len_byte = message_length_reg[15:8];
            default: len_byte = message_length_reg[7:0];
        endcase
    end

    always_comb
    begin
        header_pos_next    = header_pos_reg;
        bytes_done_next    = bytes_done_reg;
        length_seen_next   = length_seen_reg;
        mismatch_seen_next = mismatch_seen_reg;
        res.payload        = '0;
        res.last           = 1'b0;
        case (phase)
            PH_SIG:
            begin
                res.payload     = mode_reg ? extracted : sig_expect;
                header_pos_next = header_pos_reg + HDR_POS_W'(1);
                if (mode_reg && (extracted != sig_expect))
                    mismatch_seen_next = 1'b1;
            end
            PH_LEN:
            begin
                res.payload     = mode_reg ? extracted : len_byte;
                header_pos_next = header_pos_reg + HDR_POS_W'(1);
                if (mode_reg)
                    length_seen_next = {length_seen_reg[LEN_W-BYTE_W-1:0], extracted};
            end
            PH_MSG:
            begin
                res.payload     = mode_reg ? extracted : msg_byte;
                res.last        = (bytes_done_inc == total);
                bytes_done_next = bytes_done_inc;
            end
            default: ;
        endcase
        res.phase    = phase;
        res.sig_ok   = mode_reg ? !mismatch_seen_next : 1'b1;
        res.embed_en = !mode_reg && (phase != PH_PAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg    <= '0;
            bytes_done_reg    <= '0;
            length_seen_reg   <= '0;
            mismatch_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            header_pos_reg    <= header_pos_next;
            bytes_done_reg    <= bytes_done_next;
            length_seen_reg   <= length_seen_next;
            mismatch_seen_reg <= mismatch_seen_next;
        end
    end

endmodule

`default_nettype wire
